### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising edge of clk, off while rst is high.
`define STC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop on every rising edge of clk, reset included.
`define STC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STC_ASSERT(lbl, clk, rst, prop, msg)
`define STC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and helpers of the sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int STC_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [19:0] temp_raw;
    logic [19:0] press_raw;
    logic [15:0] hum_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_nine;
    logic [63:0] hum;
  } coeff_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    asr64 = $signed(x) >>> n;
  endfunction

endpackage

`default_nettype wire

### rtl/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Input side: accepts raw sample beats into a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_front #(
  parameter int QueueDepth = 2
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  stc_pkg::in_item_t    in_data,
  output stc_pkg::queue_head_t head,
  input  wire                  pop
);
  import stc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  in_item_t        slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            take;

  assign in_stall   = (count == CntW'(QueueDepth));
  assign push       = in_valid && !in_stall;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/stc_mul64.sv
// ----------------------------------------------------------------------------
// stc_mul64
// 64x64 product modulo 2^64 from one 32x32 multiplier in three passes.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_mul64 (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] a,
  input  wire  [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic [1:0]  ph;
  logic        busy;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  always_comb begin
    case (ph)
      PH_LL:   begin mx = a_r[31:0];  my = b_r[31:0];  end
      PH_LH:   begin mx = a_r[31:0];  my = b_r[63:32]; end
      PH_HL:   begin mx = a_r[63:32]; my = b_r[31:0];  end
      default: begin mx = '0;         my = '0;         end
    endcase
  end

  assign pp     = {32'b0, mx} * {32'b0, my};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      case (ph)
        PH_LL:   acc <= pp;
        default: acc <= acc + {pp[31:0], 32'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= PH_LL;
    end else begin
      done <= !start && busy && (ph == PH_HL);
      if (start) begin
        busy <= 1'b1;
        ph   <= PH_LL;
      end else if (busy) begin
        if (ph == PH_HL) begin
          busy <= 1'b0;
        end else begin
          ph <= ph + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/stc_div64.sv
// ----------------------------------------------------------------------------
// stc_div64
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_div64 (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  localparam int Bits = 64;
  localparam int CntW = $clog2(Bits);

  logic [Bits:0]   rem;
  logic [Bits-1:0] quo;
  logic [Bits-1:0] dd;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [Bits:0]   rem_sh;
  logic            ge;

  assign rem_sh   = {rem[Bits-1:0], quo[Bits-1]};
  assign ge       = (rem_sh >= {1'b0, dd});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dd  <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dd}) : rem_sh;
      quo <= {quo[Bits-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CntW'(Bits - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Bits - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back
// Compensation sequencer over a shared multiplier and divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_back (
  input  wire                  clk,
  input  wire                  rst,
  input  stc_pkg::coeff_t      coeffs,
  input  stc_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output stc_pkg::out_item_t   out_data
);
  import stc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam int StepW = 5;
  localparam logic [StepW-1:0] STEP_T0 = 5'd0;
  localparam logic [StepW-1:0] STEP_T1 = 5'd1;
  localparam logic [StepW-1:0] STEP_T2 = 5'd2;
  localparam logic [StepW-1:0] STEP_T3 = 5'd3;
  localparam logic [StepW-1:0] STEP_P0 = 5'd4;
  localparam logic [StepW-1:0] STEP_P1 = 5'd5;
  localparam logic [StepW-1:0] STEP_P2 = 5'd6;
  localparam logic [StepW-1:0] STEP_P3 = 5'd7;
  localparam logic [StepW-1:0] STEP_P4 = 5'd8;
  localparam logic [StepW-1:0] STEP_P5 = 5'd9;
  localparam logic [StepW-1:0] STEP_P6 = 5'd10;
  localparam logic [StepW-1:0] STEP_P7 = 5'd11;
  localparam logic [StepW-1:0] STEP_P8 = 5'd12;
  localparam logic [StepW-1:0] STEP_P9 = 5'd13;
  localparam logic [StepW-1:0] STEP_H0 = 5'd14;
  localparam logic [StepW-1:0] STEP_H1 = 5'd15;
  localparam logic [StepW-1:0] STEP_H2 = 5'd16;
  localparam logic [StepW-1:0] STEP_H3 = 5'd17;
  localparam logic [StepW-1:0] STEP_H4 = 5'd18;
  localparam logic [StepW-1:0] STEP_H5 = 5'd19;
  localparam logic [StepW-1:0] STEP_H6 = 5'd20;
  localparam logic [StepW-1:0] STEP_H7 = 5'd21;

  state_t           state;
  logic [StepW-1:0] step;

  // item and work registers
  logic [19:0] ut;
  logic [19:0] up;
  logic [15:0] uh;
  logic [31:0] v1;
  logic [31:0] tmp32;
  logic [31:0] tf;
  logic [23:0] temp_out;
  logic [63:0] ww;
  logic [63:0] w2;
  logic [63:0] x1;
  logic [63:0] var1;
  logic        dneg;
  logic [63:0] pq;
  logic [63:0] tmp64;
  logic [63:0] c1;
  logic [63:0] c2;
  logic [31:0] press_out;
  logic [31:0] hlhs;
  logic [31:0] ha;
  logic [31:0] hb;
  logic [31:0] hinner;
  logic [31:0] hrhs;
  logic [31:0] hx;
  logic [31:0] hs;
  logic [16:0] hum_out;
  logic        zero;

  // shared units
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] prod;
  logic        div_start;
  logic [63:0] div_n;
  logic [63:0] div_d;
  logic        div_done;
  logic [63:0] div_q;

  // coefficient fields
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h5, h6;
  logic [11:0] h4;

  // derived operands and step results
  logic [31:0] a32, b32, xh;
  logic [63:0] w1, pbase, pdiv_in, q13, var1_new, psum;
  logic [31:0] p32, t_round, hfin, hclamp, psat;

  logic        out_load;

  assign t1 = {16'b0, coeffs.temp[15:0]};
  assign t2 = {{16{coeffs.temp[31]}}, coeffs.temp[31:16]};
  assign t3 = {{16{coeffs.temp[47]}}, coeffs.temp[47:32]};
  assign p1 = {48'b0, coeffs.press_low[15:0]};
  assign p2 = {{48{coeffs.press_low[31]}}, coeffs.press_low[31:16]};
  assign p3 = {{48{coeffs.press_low[47]}}, coeffs.press_low[47:32]};
  assign p4 = {{48{coeffs.press_low[63]}}, coeffs.press_low[63:48]};
  assign p5 = {{48{coeffs.press_high[15]}}, coeffs.press_high[15:0]};
  assign p6 = {{48{coeffs.press_high[31]}}, coeffs.press_high[31:16]};
  assign p7 = {{48{coeffs.press_high[47]}}, coeffs.press_high[47:32]};
  assign p8 = {{48{coeffs.press_high[63]}}, coeffs.press_high[63:48]};
  assign p9 = {{48{coeffs.press_nine[15]}}, coeffs.press_nine};
  assign h1 = {24'b0, coeffs.hum[7:0]};
  assign h2 = {{16{coeffs.hum[23]}}, coeffs.hum[23:8]};
  assign h3 = {24'b0, coeffs.hum[31:24]};
  assign h4 = coeffs.hum[43:32];
  assign h5 = {20'b0, coeffs.hum[55:44]};
  assign h6 = {{24{coeffs.hum[63]}}, coeffs.hum[63:56]};

  assign a32     = {15'b0, ut[19:3]} - {15'b0, t1[15:0], 1'b0};
  assign b32     = {16'b0, ut[19:4]} - t1;
  assign xh      = tf - 32'd76800;
  assign w1      = {{32{tf[31]}}, tf} - 64'd128000;
  assign pbase   = 64'd1048576 - {44'b0, up};
  assign pdiv_in = (pbase << 31) - w2;
  assign q13     = asr64(pq, 13);
  assign p32     = prod[31:0];
  assign t_round = asr32(p32 + 32'd128, 8);
  assign var1_new = asr64(prod, 33);
  assign psum    = asr64(pq + c1 + c2, 8) + (p7 << 4);
  assign psat    = psum[63] ? 32'd0 : ((|psum[62:32]) ? 32'hFFFF_FFFF : psum[31:0]);
  assign hfin    = hx - asr32(p32, 4);
  assign hclamp  = hfin[31] ? 32'd0 :
                   ((hfin > 32'd419430400) ? 32'd419430400 : hfin);

  // operand select for the step being issued
  always_comb begin
    case (step)
      STEP_T0: begin mul_a = {32'b0, a32};    mul_b = {32'b0, t2};    end
      STEP_T1: begin mul_a = {32'b0, b32};    mul_b = {32'b0, b32};   end
      STEP_T2: begin mul_a = {32'b0, tmp32};  mul_b = {32'b0, t3};    end
      STEP_T3: begin mul_a = {32'b0, tf};     mul_b = 64'd5;          end
      STEP_P0: begin mul_a = w1;              mul_b = w1;             end
      STEP_P1: begin mul_a = ww;              mul_b = p6;             end
      STEP_P2: begin mul_a = w1;              mul_b = p5;             end
      STEP_P3: begin mul_a = ww;              mul_b = p3;             end
      STEP_P4: begin mul_a = w1;              mul_b = p2;             end
      STEP_P5: begin mul_a = 64'h0000_8000_0000_0000 + x1; mul_b = p1; end
      STEP_P6: begin mul_a = pdiv_in;         mul_b = 64'd3125;       end
      STEP_P7: begin mul_a = p9;              mul_b = q13;            end
      STEP_P8: begin mul_a = tmp64;           mul_b = q13;            end
      STEP_P9: begin mul_a = p8;              mul_b = pq;             end
      STEP_H0: begin mul_a = {32'b0, h5};     mul_b = {32'b0, xh};    end
      STEP_H1: begin mul_a = {32'b0, xh};     mul_b = {32'b0, h6};    end
      STEP_H2: begin mul_a = {32'b0, xh};     mul_b = {32'b0, h3};    end
      STEP_H3: begin mul_a = {32'b0, ha};     mul_b = {32'b0, hb};    end
      STEP_H4: begin mul_a = {32'b0, hinner}; mul_b = {32'b0, h2};    end
      STEP_H5: begin mul_a = {32'b0, hlhs};   mul_b = {32'b0, hrhs};  end
      STEP_H6: begin mul_a = {32'b0, hs};     mul_b = {32'b0, hs};    end
      STEP_H7: begin mul_a = {32'b0, ha};     mul_b = {32'b0, h1};    end
      default: begin mul_a = '0;              mul_b = '0;             end
    endcase
  end

  assign mul_start = (state == ST_ISSUE);
  assign div_start = (state == ST_MUL) && mul_done && (step == STEP_P6);
  assign div_n     = prod[63] ? (64'd0 - prod) : prod;
  assign div_d     = var1[63] ? (64'd0 - var1) : var1;
  assign pop       = (state == ST_IDLE) && head.valid;
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  stc_mul64 u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (prod)
  );

  stc_div64 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ut <= head.item.temp_raw;
      up <= head.item.press_raw;
      uh <= head.item.hum_raw;
    end
    if ((state == ST_ISSUE) && (step == STEP_H0)) begin
      press_out <= psat;
    end
    if ((state == ST_DIV) && div_done) begin
      pq <= dneg ? (64'd0 - div_q) : div_q;
    end
    if ((state == ST_MUL) && mul_done) begin
      case (step)
        STEP_T0: v1       <= asr32(p32, 11);
        STEP_T1: tmp32    <= asr32(p32, 12);
        STEP_T2: tf       <= v1 + asr32(p32, 14);
        STEP_T3: temp_out <= t_round[23:0];
        STEP_P0: ww       <= prod;
        STEP_P1: w2       <= prod;
        STEP_P2: w2       <= w2 + (prod << 17) + (p4 << 35);
        STEP_P3: x1       <= asr64(prod, 8);
        STEP_P4: x1       <= x1 + (prod << 12);
        STEP_P5: begin
          var1      <= var1_new;
          zero      <= (var1_new == 64'd0);
          press_out <= '0;
          hum_out   <= '0;
        end
        STEP_P6: dneg     <= prod[63] ^ var1[63];
        STEP_P7: tmp64    <= prod;
        STEP_P8: c1       <= asr64(prod, 25);
        STEP_P9: c2       <= asr64(prod, 19);
        STEP_H0: hlhs     <= asr32({2'b0, uh, 14'b0} - {h4, 20'b0} - p32 + 32'd16384, 15);
        STEP_H1: ha       <= asr32(p32, 10);
        STEP_H2: hb       <= asr32(p32, 11) + 32'd32768;
        STEP_H3: hinner   <= asr32(p32, 10) + 32'd2097152;
        STEP_H4: hrhs     <= asr32(p32 + 32'd8192, 14);
        STEP_H5: begin
          hx <= p32;
          hs <= asr32(p32, 15);
        end
        STEP_H6: ha       <= asr32(p32, 7);
        STEP_H7: hum_out  <= hclamp[28:12];
        default: v1       <= v1;
      endcase
    end
    if (out_load) begin
      out_data.temp_centi  <= $signed(temp_out);
      out_data.press_q24_8 <= press_out;
      out_data.hum_q22_10  <= hum_out;
      out_data.status      <= zero;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_T0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            step  <= STEP_T0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            if ((step == STEP_P5) && (var1_new == 64'd0)) begin
              state <= ST_OUT;
            end else if (step == STEP_P6) begin
              state <= ST_DIV;
            end else if (step == STEP_H7) begin
              state <= ST_OUT;
            end else begin
              step  <= step + 1'b1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step  <= STEP_P7;
            state <= ST_ISSUE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sensor_thp_compensation.sv
// ----------------------------------------------------------------------------
// sensor_thp_compensation
// Integer temperature / pressure / humidity compensation of raw sensor beats.
// ----------------------------------------------------------------------------
// Each input beat carries one raw triple (20-bit temperature, 20-bit pressure,
// 16-bit humidity) and yields exactly one output beat: temperature in 0.01
// degC, pressure in Q24.8 Pa (saturated to 0..2^32-1) and humidity in Q22.10
// %RH clamped to 0..100 %. If the pressure divisor works out to zero, status
// is set and pressure and humidity read as zero. Calibration coefficients sit
// in five registers written through the plain write port; write them only
// while no beat is in flight. Every product goes through one shared 32x32
// multiplier in three passes (up to 22 products), and the pressure quotient
// comes from a 64-bit divider that retires one bit per cycle. Input beats are
// queued in front of the sequencer and the result sits in an output register,
// so input keeps flowing until the queue fills while a finished result waits
// to be taken.
`default_nettype none
`include "assert_macros.svh"

module sensor_thp_compensation #(
  parameter int QueueDepth = stc_pkg::STC_QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  stc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output stc_pkg::out_item_t out_data,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [63:0]        cfg_data
);
  import stc_pkg::*;

  // register map
  localparam logic [2:0] CFG_TEMP       = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_NINE = 3'd3;
  localparam logic [2:0] CFG_HUM        = 3'd4;

  coeff_t      coeffs;
  queue_head_t head;
  logic        pop;

  // Hold coefficients; drop writes to indexes outside the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP:       coeffs.temp       <= cfg_data[47:0];
        CFG_PRESS_LOW:  coeffs.press_low  <= cfg_data;
        CFG_PRESS_HIGH: coeffs.press_high <= cfg_data;
        CFG_PRESS_NINE: coeffs.press_nine <= cfg_data[15:0];
        CFG_HUM:        coeffs.hum        <= cfg_data;
        default:        coeffs            <= coeffs;
      endcase
    end
  end

  // Front: accept beats into the queue.
  stc_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // Back: run the formulas and present the result beat.
  stc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coeffs    (coeffs),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A zero divisor must zero both dependent fields.
  `STC_ASSERT(a_zero_div_fields, clk, rst, out_valid && out_data.status |-> out_data.press_q24_8 == 32'd0 && out_data.hum_q22_10 == 17'd0, "status set with nonzero pressure or humidity")
  // Humidity never leaves the clamp range.
  `STC_ASSERT(a_hum_clamp, clk, rst, out_valid |-> out_data.hum_q22_10 <= 17'd102400, "humidity above 100 percent")
  // Pop only from a filled queue.
  `STC_ASSERT(a_pop_nonempty, clk, rst, pop |-> head.valid, "pop from empty queue")
  // No result beat right after reset.
  `STC_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sensor_thp_compensation: a local predictor runs the
// integer compensation on every accepted raw triple, and each output beat is
// checked field by field against the oldest prediction. Calibration is
// changed between phases only, with the block drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stc_pkg::*;

  // Register map of the write port.
  localparam logic [2:0] REG_TEMP       = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_NINE = 3'd3;
  localparam logic [2:0] REG_HUM        = 3'd4;
  localparam logic [2:0] REG_SPARE      = 3'd5;
  localparam logic [2:0] REG_SPARE_6    = 3'd6;
  localparam logic [2:0] REG_SPARE_7    = 3'd7;

  // Watchdog limit; allow several times the slowest run.
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  coeff_t      cal;             // calibration as the block should hold it
  out_item_t   pending_q[$];    // predicted compensated readings, oldest first
  logic        idle_en = 1'b1;  // random gaps on both sides
  int          cycle_cnt = 0;
  int          mismatch_cnt = 0;

  sensor_thp_compensation uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Arithmetic right shifts; the formal is signed, so the caller's wrap at
  // the path width happens before the shift.
  function automatic logic [31:0] sra32(input logic signed [31:0] x, input int n);
    return x >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic signed [63:0] x, input int n);
    return x >>> n;
  endfunction

  // Signed divide truncating toward zero, built on magnitudes so that the
  // most negative dividend over minus one wraps to itself.
  function automatic logic [63:0] sdiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] mn, md, quo;
    mn  = num[63] ? -num : num;
    md  = den[63] ? -den : den;
    quo = mn / md;
    return (num[63] != den[63]) ? -quo : quo;
  endfunction

  // Compensate one raw triple with the current calibration.
  function automatic out_item_t compensate(input in_item_t d);
    logic [31:0] ut, uh, t1, t2, t3, a, v1, b, v2, tf, tc;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, lhs, inner, rhs, s;
    logic [63:0] up, p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, c1, c2;
    out_item_t   r;
    ut = {12'd0, d.temp_raw};
    up = {44'd0, d.press_raw};
    uh = {16'd0, d.hum_raw};
    r  = '0;

    // temperature, 32-bit wrap
    t1 = {16'd0, cal.temp[15:0]};
    t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
    t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};
    a  = (ut >> 3) - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b  = (ut >> 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    tf = v1 + v2;
    tc = sra32(tf * 32'd5 + 32'd128, 8);
    r.temp_centi = tc[23:0];

    // pressure, 64-bit wrap
    p1 = {48'd0, cal.press_low[15:0]};
    p2 = {{48{cal.press_low[31]}}, cal.press_low[31:16]};
    p3 = {{48{cal.press_low[47]}}, cal.press_low[47:32]};
    p4 = {{48{cal.press_low[63]}}, cal.press_low[63:48]};
    p5 = {{48{cal.press_high[15]}}, cal.press_high[15:0]};
    p6 = {{48{cal.press_high[31]}}, cal.press_high[31:16]};
    p7 = {{48{cal.press_high[47]}}, cal.press_high[47:32]};
    p8 = {{48{cal.press_high[63]}}, cal.press_high[63:48]};
    p9 = {{48{cal.press_nine[15]}}, cal.press_nine};
    w1 = {{32{tf[31]}}, tf} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
    if (w1 == 64'd0) begin
      // zero divisor: flag it, drop pressure and humidity
      r.status = 1'b1;
      return r;
    end
    p  = 64'd1048576 - up;
    p  = sdiv64(((p << 31) - w2) * 64'd3125, w1);
    q  = sra64(p, 13);
    c1 = sra64(p9 * q * q, 25);
    c2 = sra64(p8 * p, 19);
    p  = sra64(p + c1 + c2, 8) + (p7 << 4);
    if (p[63]) r.press_q24_8 = '0;
    else if (p > 64'hFFFF_FFFF) r.press_q24_8 = '1;
    else r.press_q24_8 = p[31:0];

    // humidity, 32-bit wrap
    h1 = {24'd0, cal.hum[7:0]};
    h2 = {{16{cal.hum[23]}}, cal.hum[23:8]};
    h3 = {24'd0, cal.hum[31:24]};
    h4 = {20'd0, cal.hum[43:32]};
    h5 = {20'd0, cal.hum[55:44]};
    h6 = {{24{cal.hum[63]}}, cal.hum[63:56]};
    x     = tf - 32'd76800;
    lhs   = sra32((uh << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    inner = sra32(sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
    rhs   = sra32(inner * h2 + 32'd8192, 14);
    x     = lhs * rhs;
    s     = sra32(x, 15);
    x     = x - sra32(sra32(s * s, 7) * h1, 4);
    if (x[31]) x = '0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.hum_q22_10 = x[28:12];
    return r;
  endfunction

  // Output side: stall at random on the falling edge, check on the rising.
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output beat %h", out_data);
        mismatch_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.temp_centi !== want.temp_centi) begin
          $error("temp_centi: expected %0d, got %0d", want.temp_centi, out_data.temp_centi);
          mismatch_cnt++;
        end
        if (out_data.press_q24_8 !== want.press_q24_8) begin
          $error("press_q24_8: expected %0d, got %0d", want.press_q24_8,
                 out_data.press_q24_8);
          mismatch_cnt++;
        end
        if (out_data.hum_q22_10 !== want.hum_q22_10) begin
          $error("hum_q22_10: expected %0d, got %0d", want.hum_q22_10, out_data.hum_q22_10);
          mismatch_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL sensor_thp_compensation");
      $finish;
    end
  end

  // Send one raw triple; enter and leave on a falling edge with valid held.
  task automatic send_sample(input in_item_t d);
    while (idle_en && ($urandom_range(99) < 14)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(compensate(d));
    @(negedge clk);
  endtask

  function automatic in_item_t rand_sample();
    in_item_t d;
    d.temp_raw  = 20'($urandom);
    d.press_raw = 20'($urandom);
    d.hum_raw   = 16'($urandom);
    return d;
  endfunction

  // Raw values near a plausible room reading, with some spread.
  function automatic in_item_t room_sample();
    in_item_t d;
    d.temp_raw  = 20'($urandom_range(560000, 440000));
    d.press_raw = 20'($urandom_range(480000, 250000));
    d.hum_raw   = 16'($urandom_range(50000, 15000));
    return d;
  endfunction

  // Hold valid low, wait for every prediction to come back, then let the
  // sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write one register at a falling edge and track it, then idle with the write enable low.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEMP:       cal.temp       = val[47:0];
      REG_PRESS_LOW:  cal.press_low  = val;
      REG_PRESS_HIGH: cal.press_high = val;
      REG_PRESS_NINE: cal.press_nine = val[15:0];
      REG_HUM:        cal.hum        = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                          input logic [63:0] ph, input logic [15:0] p9,
                          input logic [63:0] hc);
    write_reg(REG_TEMP, {16'hA5A5, tc});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_PRESS_NINE, {48'h5A5A_5A5A_5A5A, p9});
    write_reg(REG_HUM, hc);
  endtask

  // A typical calibration set.
  task automatic load_typical();
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
             {-16'sd14600, 16'd15500, -16'sd7, 16'd140},
             16'd6000,
             {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
  endtask

  task automatic load_random_cal();
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
             16'($urandom), {$urandom, $urandom});
  endtask

  // Reset calibration is all zero, so the divisor is zero: status only.
  // Then field extremes and the indexes past the map under a typical set.
  task automatic test_directed();
    in_item_t d;
    send_sample('0);
    send_sample('1);
    drain();
    load_typical();
    write_reg(REG_SPARE, '1);
    write_reg(REG_SPARE_6, '0);
    write_reg(REG_SPARE_7, '1);
    send_sample('0);
    send_sample('1);
    d = '0; d.temp_raw = '1; send_sample(d);
    d = '0; d.press_raw = '1; send_sample(d);
    d = '0; d.hum_raw = '1; send_sample(d);
    d = '1; d.press_raw = '0; send_sample(d);
    d.temp_raw = 20'd519888; d.press_raw = 20'd415148; d.hum_raw = 16'd30000;
    send_sample(d);
    d.hum_raw = 16'd65000; send_sample(d);   // drive humidity to its top clamp
    d.hum_raw = 16'd100;   send_sample(d);   // and to its bottom clamp
    d.press_raw = 20'd1;   send_sample(d);
    d.press_raw = 20'hFFFFF; send_sample(d);
    drain();
    // P1 of zero forces a zero divisor with live temperature
    write_reg(REG_PRESS_LOW, 64'h0B27_0BD0_D641_0000);
    for (int i = 0; i < 4; i++) send_sample(room_sample());
    drain();
  endtask

  // Long run under the typical set, first with no gaps at all.
  task automatic test_typical();
    load_typical();
    idle_en = 1'b0;
    for (int i = 0; i < 300; i++) send_sample(room_sample());
    idle_en = 1'b1;
    for (int i = 0; i < 400; i++) begin
      send_sample(($urandom_range(3) == 0) ? rand_sample() : room_sample());
      // hold off once until the pipe is empty
      if (i == 200) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
    end
    drain();
  endtask

  // Fully random calibration, including the sign bits of every coefficient.
  task automatic test_random_cal();
    for (int k = 0; k < 12; k++) begin
      load_random_cal();
      for (int i = 0; i < 85; i++) send_sample(rand_sample());
      drain();
    end
  endtask

  // Coefficient extremes: all ones, all zero, most negative and most positive slices.
  task automatic test_extreme_cal();
    load_cal('1, '1, '1, '1, '1);
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
    load_cal('0, '0, '0, '0, '0);
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
    drain();
    load_cal(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
             16'h8000, 64'h80FF_FFFF_FF80_00FF);
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
    load_cal(48'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
             16'h7FFF, 64'h7F00_0000_0000_7F00);
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    cal = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_typical();
    test_random_cal();
    test_extreme_cal();
    drain();
    repeat (200) @(negedge clk);
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS sensor_thp_compensation");
    end else begin
      $display("FAIL sensor_thp_compensation");
    end
    $finish;
  end

endmodule
